// ===== rtl/skq_pkg.sv =====
package skq_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 16;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int KIND_W    = 3;
  localparam int REQ_KEY_W = 16;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;
  localparam int WIDE_W    = ((KEY_BITS > REQ_KEY_W) ? KEY_BITS : REQ_KEY_W) + 1;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic signed [WIDE_W-1:0]   wide_key_t;
  typedef logic [ITEM_W-1:0]          item_t;
  typedef logic [COUNT_W-1:0]         count_t;

  localparam wide_key_t KEY_MAX_W = wide_key_t'({1'b0, {(KEY_BITS-1){1'b1}}});
  localparam wide_key_t KEY_MIN_W = wide_key_t'(-KEY_MAX_W - wide_key_t'(1));

  typedef enum logic [KIND_W-1:0] {
    REQ_PREPEND = 3'd0,
    REQ_APPEND  = 3'd1,
    REQ_POP     = 3'd2,
    REQ_SORTED  = 3'd3,
    REQ_REMOVE  = 3'd4
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PREPEND,
    CELL_APPEND,
    CELL_SORTED,
    CELL_POP,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    key_t  key;
    item_t item;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    key_t     cmp_key;
    logic     cmp_ok;
    entry_t   fresh;
  } cell_ctl_t;

  typedef struct packed {
    logic keep;
    logic after;
  } cell_link_t;

  function automatic key_t sat_key(wide_key_t v);
    key_t r;
    if (v > KEY_MAX_W) begin
      r = key_t'(KEY_MAX_W);
    end else if (v < KEY_MIN_W) begin
      r = key_t'(KEY_MIN_W);
    end else begin
      r = key_t'(v);
    end
    return r;
  endfunction

  function automatic logic key_in_range(wide_key_t v);
    return (v <= KEY_MAX_W) && (v >= KEY_MIN_W);
  endfunction

endpackage

// ===== rtl/skq_req_if.sv =====
interface skq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [skq_pkg::KIND_W-1:0]             req_type;
  logic signed [skq_pkg::REQ_KEY_W-1:0]   req_key;
  logic [skq_pkg::ITEM_W-1:0]             item_handle;

  modport source(output valid, req_type, req_key, item_handle, input ready);
  modport sink(input valid, req_type, req_key, item_handle, output ready);
endinterface

// ===== rtl/skq_rsp_if.sv =====
interface skq_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [skq_pkg::STATUS_W-1:0]           status;
  logic [skq_pkg::ITEM_W-1:0]             out_item;
  logic signed [skq_pkg::REQ_KEY_W-1:0]   out_key;
  logic [skq_pkg::OCC_W-1:0]              occupancy;

  modport source(output valid, status, out_item, out_key, occupancy, input ready);
  modport sink(input valid, status, out_item, out_key, occupancy, output ready);
endinterface

// ===== rtl/sorted_key_queue_top.sv =====
// A request is applied in the cycle it is accepted; its response is
// registered and shows in the next cycle.
// Throughput: one request per cycle, unless a held response is not yet taken. Every cell compares against the broadcast
// key in parallel and shifts by at most one slot, so no request takes longer.
// Reset clears the entry count and the response valid; stored keys and items
// are not cleared and only slots below the count are ever read.
module sorted_key_queue_top (
  input logic      clk,
  input logic      rst,
  skq_req_if.sink  req,
  skq_rsp_if.source rsp
);

  localparam int N = skq_pkg::CAPACITY;

  skq_pkg::count_t    count;
  skq_pkg::count_t    count_next;
  logic [N-1:0]       valid;
  skq_pkg::entry_t    cur [N];
  skq_pkg::cell_link_t link [N];
  logic [N-1:0]       hit;
  skq_pkg::cell_ctl_t ctl;
  skq_pkg::key_t      tail_key;
  skq_pkg::item_t     hit_item;
  logic               accept;
  logic               full;
  logic               empty;
  skq_pkg::wide_key_t req_wide;
  skq_pkg::status_t   status_next;
  skq_pkg::item_t     item_next;
  skq_pkg::key_t      key_next;
  skq_pkg::status_t   status;
  skq_pkg::item_t     out_item;
  skq_pkg::key_t      out_key;
  skq_pkg::count_t    occupancy;
  logic               rsp_valid;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == skq_pkg::count_t'(N));
  assign empty     = (count == '0);
  assign req_wide  = skq_pkg::wide_key_t'(req.req_key);

  always_comb begin
    tail_key = '0;
    hit_item = '0;
    for (int i = 0; i < N; i++) begin
      if (valid[i] && ((i == N - 1) || !valid[(i + 1) % N])) begin
        tail_key = tail_key | cur[i].key;
      end
      if (hit[i]) begin
        hit_item = hit_item | cur[i].item;
      end
    end
  end

  // cell control: depends only on the request, the stored state and the response ready
  always_comb begin
    ctl.op          = skq_pkg::CELL_HOLD;
    ctl.cmp_key     = skq_pkg::sat_key(req_wide);
    ctl.cmp_ok      = skq_pkg::key_in_range(req_wide);
    ctl.fresh.item  = req.item_handle;
    ctl.fresh.key   = '0;
    unique case (skq_pkg::req_kind_t'(req.req_type))
      skq_pkg::REQ_PREPEND: begin
        if (!full) begin
          ctl.op = skq_pkg::CELL_PREPEND;
          if (!empty) begin
            ctl.fresh.key = skq_pkg::sat_key(
              skq_pkg::wide_key_t'(cur[0].key) - skq_pkg::wide_key_t'(1));
          end
        end
      end
      skq_pkg::REQ_APPEND: begin
        if (!full) begin
          ctl.op = skq_pkg::CELL_APPEND;
          if (!empty) begin
            ctl.fresh.key = skq_pkg::sat_key(
              skq_pkg::wide_key_t'(tail_key) + skq_pkg::wide_key_t'(1));
          end
        end
      end
      skq_pkg::REQ_SORTED: begin
        if (!full) begin
          ctl.op        = skq_pkg::CELL_SORTED;
          ctl.fresh.key = skq_pkg::sat_key(req_wide);
        end
      end
      skq_pkg::REQ_POP: begin
        if (!empty) begin
          ctl.op = skq_pkg::CELL_POP;
        end
      end
      skq_pkg::REQ_REMOVE: ctl.op = skq_pkg::CELL_REMOVE;
      default:             ctl.op = skq_pkg::CELL_HOLD;
    endcase
    // drop the request into the cells only on acceptance
    if (!accept) begin
      ctl.op = skq_pkg::CELL_HOLD;
    end
  end

  always_comb begin
    status_next = skq_pkg::ST_OK;
    item_next   = '0;
    key_next    = '0;
    count_next  = count;
    unique case (skq_pkg::req_kind_t'(req.req_type)) inside
      skq_pkg::REQ_PREPEND, skq_pkg::REQ_APPEND, skq_pkg::REQ_SORTED: begin
        if (full) begin
          status_next = skq_pkg::ST_FULL;
        end else begin
          count_next = count + skq_pkg::count_t'(1);
        end
      end
      skq_pkg::REQ_POP: begin
        if (empty) begin
          status_next = skq_pkg::ST_MISS;
        end else begin
          item_next  = cur[0].item;
          key_next   = cur[0].key;
          count_next = count - skq_pkg::count_t'(1);
        end
      end
      skq_pkg::REQ_REMOVE: begin
        if (|hit) begin
          item_next  = hit_item;
          count_next = count - skq_pkg::count_t'(1);
        end else begin
          status_next = skq_pkg::ST_MISS;
        end
      end
      default: status_next = skq_pkg::ST_OK;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    skq_pkg::entry_t     left_e;
    skq_pkg::entry_t     right_e;
    skq_pkg::cell_link_t left_l;

    assign valid[i] = (count > skq_pkg::count_t'(i));

    if (i == 0) begin : g_head
      assign left_e      = '0;
      assign left_l.keep = 1'b1;
      assign left_l.after = 1'b0;
    end else begin : g_body
      assign left_e = cur[i-1];
      assign left_l = link[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cur[i+1];
    end

    skq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (valid[i]),
      .left      (left_e),
      .right     (right_e),
      .left_link (left_l),
      .cur       (cur[i]),
      .link      (link[i]),
      .hit       (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      out_item  <= item_next;
      out_key   <= key_next;
      occupancy <= count_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status;
  assign rsp.out_item  = out_item;
  assign rsp.out_key   = skq_pkg::REQ_KEY_W'(out_key);
  assign rsp.occupancy = skq_pkg::OCC_W'(occupancy);

endmodule

// ===== rtl/skq_cell.sv =====
module skq_cell (
  input  logic                clk,
  input  skq_pkg::cell_ctl_t  ctl,
  input  logic                valid,
  input  skq_pkg::entry_t     left,
  input  skq_pkg::entry_t     right,
  input  skq_pkg::cell_link_t left_link,
  output skq_pkg::entry_t     cur,
  output skq_pkg::cell_link_t link,
  output logic                hit
);

  skq_pkg::entry_t slot;
  skq_pkg::entry_t slot_next;
  logic            gt;
  logic            match;

  always_comb begin
    gt    = valid && (slot.key > ctl.cmp_key);
    match = valid && ctl.cmp_ok && (slot.key == ctl.cmp_key);
    hit   = (ctl.op == skq_pkg::CELL_REMOVE) && match && !left_link.after;

    link.keep  = 1'b1;
    link.after = 1'b0;
    case (ctl.op)
      skq_pkg::CELL_PREPEND: link.keep = 1'b0;
      skq_pkg::CELL_APPEND:  link.keep = valid;
      skq_pkg::CELL_SORTED:  link.keep = valid && !gt;
      skq_pkg::CELL_POP:     link.after = 1'b1;
      skq_pkg::CELL_REMOVE:  link.after = left_link.after || match;
      default:               link.keep = 1'b1;
    endcase

    slot_next = slot;
    case (ctl.op) inside
      skq_pkg::CELL_PREPEND, skq_pkg::CELL_APPEND, skq_pkg::CELL_SORTED: begin
        // open the gap: the first cell that moves takes the new entry
        if (!link.keep) begin
          slot_next = left_link.keep ? ctl.fresh : left;
        end
      end
      skq_pkg::CELL_POP, skq_pkg::CELL_REMOVE: begin
        if (link.after) begin
          slot_next = right;
        end
      end
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  assign cur = slot;

endmodule
